// File: hw/rtl/xmlcc_pkg.sv
// xmlcc_pkg: shared types, character codes and helpers for the xml markup
// character classifier. no dependencies.
`timescale 1ns / 1ps

package xmlcc_pkg;

   localparam int CHAR_BITS    = 16;
   localparam int MAX_RESULTS  = 3;
   localparam int HOLD_DEPTH   = 3;
   localparam int QUEUE_DEPTH  = 4;

   typedef logic [CHAR_BITS-1:0] char_type;

   localparam char_type CH_LT    = char_type'(8'h3C);
   localparam char_type CH_GT    = char_type'(8'h3E);
   localparam char_type CH_AMP   = char_type'(8'h26);
   localparam char_type CH_SEMI  = char_type'(8'h3B);
   localparam char_type CH_BANG  = char_type'(8'h21);
   localparam char_type CH_DASH  = char_type'(8'h2D);
   localparam char_type CH_DQUOT = char_type'(8'h22);
   localparam char_type CH_SQUOT = char_type'(8'h27);

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_TAG     = 3'd1,
      MODE_DQUOTE  = 3'd2,
      MODE_SQUOTE  = 3'd3,
      MODE_COMMENT = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CLS_PLAIN   = 3'd0,
      CLS_ENTITY  = 3'd1,
      CLS_TAG     = 3'd2,
      CLS_ATTR    = 3'd3,
      CLS_COMMENT = 3'd4
   } class_type;

   typedef enum logic {
      KIND_CHAR = 1'b0,
      KIND_EOL  = 1'b1
   } kind_type;

   typedef struct packed {
      logic     item_kind;
      char_type char_code;
   } req_type;

   typedef struct packed {
      char_type  out_char;
      class_type char_class;
      logic      last_of_run;
   } rsp_type;

   // up to three classified characters made by one item
   typedef struct packed {
      logic [1:0]                      cnt;
      logic [MAX_RESULTS-1:0][CHAR_BITS-1:0] chars;
      class_type [MAX_RESULTS-1:0]     classes;
   } bundle_type;

   // characters that follow '<' in a comment opener
   function automatic char_type opener_tail(input logic [1:0] pos);
      char_type c;
      unique case (pos)
         2'd0:    c = CH_BANG;
         default: c = CH_DASH;
      endcase
      return c;
   endfunction

endpackage

// File: hw/rtl/xml_markup_char_classifier.sv
// xml_markup_char_classifier: top level, front classifier, bundle queue and
// result sender. depends on xmlcc_pkg, xmlcc_front, xmlcc_fifo, xmlcc_back.
`timescale 1ns / 1ps

//  channel   direction  ports                               item
//  req       in         req_valid, req_ready, req_payload   char or line end
//  rsp       out        rsp_valid, rsp_ready, rsp_payload   classified char
//
//  an input item is taken every cycle while the bundle queue has room; each
//  item makes zero to three results, sent one a cycle by the back end while rsp_ready is high
//  results of an item pass through the bundle queue and the back end's bundle register before they are offered
//  sustained rate is one result per cycle while rsp_ready is high, set by the single output register
//  reset clears lexer mode, entity and dash tracking, held count and queue
//  a stall on rsp fills the queue, then req_ready drops

module xml_markup_char_classifier #(
   parameter int QUEUE_DEPTH = xmlcc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  xmlcc_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output xmlcc_pkg::rsp_type  rsp_payload
);

   logic                  req_take;
   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_valid;
   xmlcc_pkg::bundle_type front_bundle;
   xmlcc_pkg::bundle_type q_data;

   // front may take an item whenever a slot is free for its bundle
   assign req_ready = !q_full;
   assign req_take  = req_valid && req_ready;

   // lexer state and three-character lookahead
   xmlcc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_take),
      .item   (req_payload),
      .push   (q_push),
      .bundle (front_bundle)
   );

   // decouples classification from output stalls
   xmlcc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_bundle),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

   // serializes each bundle, marks the last item of a run
   xmlcc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hw/rtl/xmlcc_front.sv
// xmlcc_front: lexer state, lookahead hold and per-item classification.
// depends on xmlcc_pkg.
`timescale 1ns / 1ps

module xmlcc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  xmlcc_pkg::req_type   item,
   output logic                 push,
   output xmlcc_pkg::bundle_type bundle
);

   xmlcc_pkg::mode_type mode_ff, mode_in;
   logic                ent_ff, ent_in;
   logic [1:0]          dash_ff, dash_in;
   logic [1:0]          held_cnt_ff, held_cnt_in;
   xmlcc_pkg::char_type held_ff [xmlcc_pkg::HOLD_DEPTH];
   xmlcc_pkg::char_type held_in [xmlcc_pkg::HOLD_DEPTH];

   always_comb begin
      xmlcc_pkg::char_type buf_v [4];
      xmlcc_pkg::char_type c;
      xmlcc_pkg::mode_type mode_v;
      xmlcc_pkg::class_type cls;
      logic       ent_v;
      logic [1:0] dash_v;
      logic [2:0] n;
      logic [2:0] used;
      logic [2:0] idx;
      logic [1:0] k;
      logic       stop;
      logic       eol;
      logic       mism;

      c    = '0;
      cls  = xmlcc_pkg::CLS_PLAIN;
      mism = 1'b0;
      idx  = 3'd0;
      for (int j = 0; j < 3; j++) begin
         buf_v[j] = held_ff[j];
      end
      buf_v[3] = '0;
      n   = {1'b0, held_cnt_ff};
      eol = (item.item_kind == xmlcc_pkg::KIND_EOL);
      if (!eol) begin
         buf_v[n[1:0]] = item.char_code;
         n = n + 3'd1;
      end

      mode_v = mode_ff;
      ent_v  = ent_ff;
      dash_v = dash_ff;
      k      = 2'd0;
      used   = 3'd0;
      stop   = 1'b0;
      bundle = '0;

      for (int p = 0; p < 4; p++) begin
         if ((3'(p) < n) && !stop && (k < 2'd3)) begin
            c = buf_v[p];
            // '<' in plain text waits for enough lookahead
            if (mode_v == xmlcc_pkg::MODE_NORMAL && !ent_v && c == xmlcc_pkg::CH_LT) begin
               mism = 1'b0;
               for (int j = 0; j < 3; j++) begin
                  if ((3'(p + 1 + j) < n) &&
                      buf_v[2'(p + 1 + j)] != xmlcc_pkg::opener_tail(2'(j))) begin
                     mism = 1'b1;
                  end
               end
               if (mism) begin
                  mode_v = xmlcc_pkg::MODE_TAG;
               end else if ((n - 3'(p) - 3'd1) >= 3'd3) begin
                  mode_v = xmlcc_pkg::MODE_COMMENT;
                  dash_v = 2'd0;
               end else if (eol) begin
                  mode_v = xmlcc_pkg::MODE_TAG;
               end else begin
                  stop = 1'b1;
               end
            end
            if (!stop) begin
               unique case (mode_v)
                  xmlcc_pkg::MODE_TAG: begin
                     cls = xmlcc_pkg::CLS_TAG;
                     if (c == xmlcc_pkg::CH_SQUOT) begin
                        mode_v = xmlcc_pkg::MODE_SQUOTE;
                     end else if (c == xmlcc_pkg::CH_DQUOT) begin
                        mode_v = xmlcc_pkg::MODE_DQUOTE;
                     end else if (c == xmlcc_pkg::CH_GT) begin
                        mode_v = xmlcc_pkg::MODE_NORMAL;
                     end
                  end
                  xmlcc_pkg::MODE_DQUOTE: begin
                     cls = xmlcc_pkg::CLS_ATTR;
                     if (c == xmlcc_pkg::CH_DQUOT) mode_v = xmlcc_pkg::MODE_TAG;
                  end
                  xmlcc_pkg::MODE_SQUOTE: begin
                     cls = xmlcc_pkg::CLS_ATTR;
                     if (c == xmlcc_pkg::CH_SQUOT) mode_v = xmlcc_pkg::MODE_TAG;
                  end
                  xmlcc_pkg::MODE_COMMENT: begin
                     cls = xmlcc_pkg::CLS_COMMENT;
                     if (c == xmlcc_pkg::CH_DASH) begin
                        if (dash_v < 2'd2) dash_v = dash_v + 2'd1;
                     end else if (c == xmlcc_pkg::CH_GT && dash_v == 2'd2) begin
                        mode_v = xmlcc_pkg::MODE_NORMAL;
                        dash_v = 2'd0;
                     end else begin
                        dash_v = 2'd0;
                     end
                  end
                  default: begin
                     if (ent_v) begin
                        cls = xmlcc_pkg::CLS_ENTITY;
                        if (c == xmlcc_pkg::CH_SEMI) ent_v = 1'b0;
                     end else if (c == xmlcc_pkg::CH_AMP) begin
                        cls   = xmlcc_pkg::CLS_ENTITY;
                        ent_v = 1'b1;
                     end else begin
                        cls = xmlcc_pkg::CLS_PLAIN;
                     end
                  end
               endcase
               bundle.chars[k]   = c;
               bundle.classes[k] = cls;
               k    = k + 2'd1;
               used = 3'(p + 1);
            end
         end
      end
      bundle.cnt = k;

      // whatever was not given out stays held
      for (int j = 0; j < 3; j++) begin
         idx = used + 3'(j);
         held_in[j] = (idx < 3'd4) ? buf_v[idx[1:0]] : buf_v[0];
      end
      held_cnt_in = 2'(n - used);
      mode_in     = mode_v;
      ent_in      = ent_v;
      dash_in     = dash_v;
      if (eol) begin
         held_cnt_in = 2'd0;
         ent_in      = 1'b0;
         dash_in     = 2'd0;
      end
      push = accept && (k != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= xmlcc_pkg::MODE_NORMAL;
         ent_ff      <= 1'b0;
         dash_ff     <= 2'd0;
         held_cnt_ff <= 2'd0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         ent_ff      <= ent_in;
         dash_ff     <= dash_in;
         held_cnt_ff <= held_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < 3; j++) begin
            held_ff[j] <= held_in[j];
         end
      end
   end

endmodule

// File: hw/rtl/xmlcc_fifo.sv
// xmlcc_fifo: short queue of classified bundles between front and back.
// depends on xmlcc_pkg.
`timescale 1ns / 1ps

module xmlcc_fifo #(
   parameter int DEPTH = xmlcc_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  xmlcc_pkg::bundle_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output xmlcc_pkg::bundle_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   xmlcc_pkg::bundle_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      not_empty = (count_ff != '0);
      pop_data  = mem[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/xmlcc_back.sv
// xmlcc_back: takes bundles from the queue and sends them out one item a cycle while rsp_ready is high.
// depends on xmlcc_pkg.
`timescale 1ns / 1ps

module xmlcc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  xmlcc_pkg::bundle_type q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output xmlcc_pkg::rsp_type    rsp_payload
);

   xmlcc_pkg::bundle_type bnd_ff, bnd_in;
   logic                  bvalid_ff, bvalid_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  last;
   logic                  load;

   always_comb begin
      last  = (idx_ff == 2'(bnd_ff.cnt - 2'd1));
      load  = !bvalid_ff || (rsp_ready && last);
      q_pop = load && q_valid;

      bnd_in    = bnd_ff;
      bvalid_in = bvalid_ff;
      idx_in    = idx_ff;
      if (load) begin
         bnd_in    = q_data;
         bvalid_in = q_valid;
         idx_in    = 2'd0;
      end else if (rsp_ready) begin
         idx_in = idx_ff + 2'd1;
      end

      rsp_valid               = bvalid_ff;
      rsp_payload.out_char    = bnd_ff.chars[idx_ff];
      rsp_payload.char_class  = bnd_ff.classes[idx_ff];
      rsp_payload.last_of_run = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= 1'b0;
         idx_ff    <= 2'd0;
      end else begin
         bvalid_ff <= bvalid_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bnd_ff <= bnd_in;
   end

endmodule

// File: tb/sv/tb.sv
// tb: self-checking bench for xml_markup_char_classifier, holding a class-level predictor,
// a scoreboard and handshake drivers. depends on xmlcc_pkg and the classifier rtl.
`timescale 1ns / 1ps

module tb;

   // extra character codes for building text
   localparam xmlcc_pkg::char_type CH_A     = xmlcc_pkg::char_type'(8'h61);
   localparam xmlcc_pkg::char_type CH_SPACE = xmlcc_pkg::char_type'(8'h20);
   localparam xmlcc_pkg::char_type CH_SLASH = xmlcc_pkg::char_type'(8'h2F);
   localparam xmlcc_pkg::char_type CH_EQ    = xmlcc_pkg::char_type'(8'h3D);

   localparam int RANDOM_ITEMS = 460;
   localparam int TAIL_CYCLES  = 8;

   // predicts the classes of every character and checks them in order
   class xml_class_scoreboard;
      xmlcc_pkg::mode_type mode;
      bit                  in_ent;
      xmlcc_pkg::char_type held[3];
      int                  held_n;
      int                  dashes;
      xmlcc_pkg::char_type opener[3];
      xmlcc_pkg::rsp_type  expected_chars[$];
      int                  mismatches;

      function new();
         mode       = xmlcc_pkg::MODE_NORMAL;
         in_ent     = 1'b0;
         held_n     = 0;
         dashes     = 0;
         mismatches = 0;
         opener[0]  = xmlcc_pkg::CH_BANG;
         opener[1]  = xmlcc_pkg::CH_DASH;
         opener[2]  = xmlcc_pkg::CH_DASH;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      // class of one released character, advancing the lexer mode
      function xmlcc_pkg::class_type classify(xmlcc_pkg::char_type c);
         xmlcc_pkg::class_type cls;
         case (mode)
            xmlcc_pkg::MODE_TAG: begin
               cls = xmlcc_pkg::CLS_TAG;
               if (c == xmlcc_pkg::CH_SQUOT) mode = xmlcc_pkg::MODE_SQUOTE;
               else if (c == xmlcc_pkg::CH_DQUOT) mode = xmlcc_pkg::MODE_DQUOTE;
               else if (c == xmlcc_pkg::CH_GT) mode = xmlcc_pkg::MODE_NORMAL;
            end
            xmlcc_pkg::MODE_DQUOTE: begin
               cls = xmlcc_pkg::CLS_ATTR;
               if (c == xmlcc_pkg::CH_DQUOT) mode = xmlcc_pkg::MODE_TAG;
            end
            xmlcc_pkg::MODE_SQUOTE: begin
               cls = xmlcc_pkg::CLS_ATTR;
               if (c == xmlcc_pkg::CH_SQUOT) mode = xmlcc_pkg::MODE_TAG;
            end
            xmlcc_pkg::MODE_COMMENT: begin
               cls = xmlcc_pkg::CLS_COMMENT;
               if (c == xmlcc_pkg::CH_DASH) begin
                  if (dashes < 2) dashes++;
               end else if (c == xmlcc_pkg::CH_GT && dashes == 2) begin
                  mode   = xmlcc_pkg::MODE_NORMAL;
                  dashes = 0;
               end else begin
                  dashes = 0;
               end
            end
            default: begin
               if (in_ent) begin
                  cls = xmlcc_pkg::CLS_ENTITY;
                  if (c == xmlcc_pkg::CH_SEMI) in_ent = 1'b0;
               end else if (c == xmlcc_pkg::CH_AMP) begin
                  cls    = xmlcc_pkg::CLS_ENTITY;
                  in_ent = 1'b1;
               end else begin
                  cls = xmlcc_pkg::CLS_PLAIN;
               end
            end
         endcase
         return cls;
      endfunction

      // release what can be decided from the pending characters, hold the rest
      function void release_chars(xmlcc_pkg::char_type pend[4], int n, bit eol);
         int                 i;
         int                 j;
         int                 k;
         int                 rest;
         int                 lim;
         bit                 differs;
         xmlcc_pkg::rsp_type r;
         i = 0;
         k = 0;
         while (i < n && k < xmlcc_pkg::MAX_RESULTS) begin
            if (mode == xmlcc_pkg::MODE_NORMAL && !in_ent && pend[i] == xmlcc_pkg::CH_LT) begin
               rest    = n - i - 1;
               lim     = (rest < 3) ? rest : 3;
               differs = 1'b0;
               for (j = 0; j < lim; j++)
                  if (pend[i + 1 + j] != opener[j]) differs = 1'b1;
               if (differs) begin
                  mode = xmlcc_pkg::MODE_TAG;
               end else if (rest >= 3) begin
                  mode   = xmlcc_pkg::MODE_COMMENT;
                  dashes = 0;
               end else if (eol) begin
                  mode = xmlcc_pkg::MODE_TAG;
               end else begin
                  break;
               end
               continue;
            end
            r.out_char    = pend[i];
            r.char_class  = classify(pend[i]);
            r.last_of_run = 1'b0;
            expected_chars.push_back(r);
            k++;
            i++;
         end
         held_n = 0;
         while (i < n && held_n < 3) begin
            held[held_n] = pend[i];
            held_n++;
            i++;
         end
         if (k > 0) expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
      endfunction

      // an accepted input item
      function void note_item(xmlcc_pkg::req_type item);
         xmlcc_pkg::char_type pend[4];
         int                  n;
         int                  j;
         n = held_n;
         for (j = 0; j < n; j++) pend[j] = held[j];
         if (item.item_kind == xmlcc_pkg::KIND_EOL) begin
            release_chars(pend, n, 1'b1);
            in_ent = 1'b0;
            dashes = 0;
            held_n = 0;
         end else begin
            pend[n] = item.char_code;
            release_chars(pend, n + 1, 1'b0);
         end
      endfunction

      // an accepted result, against the oldest prediction
      function void check_result(xmlcc_pkg::rsp_type got);
         xmlcc_pkg::rsp_type want;
         if (expected_chars.size() == 0) begin
            $display("%0t: result with none expected, got char %h class %0d last %0b",
                     $time, got.out_char, got.char_class, got.last_of_run);
            mismatches++;
            return;
         end
         want = expected_chars.pop_front();
         if (got.out_char !== want.out_char) begin
            $display("%0t: out_char mismatch, expected %h got %h",
                     $time, want.out_char, got.out_char);
            mismatches++;
         end
         if (got.char_class !== want.char_class) begin
            $display("%0t: char_class mismatch on %h, expected %0d got %0d",
                     $time, want.out_char, want.char_class, got.char_class);
            mismatches++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run mismatch on %h, expected %0b got %0b",
                     $time, want.out_char, want.last_of_run, got.last_of_run);
            mismatches++;
         end
      endfunction

      function void flag_leftovers();
         if (expected_chars.size() != 0) begin
            $display("%0t: %0d results never came, first expected char %h class %0d",
                     $time, expected_chars.size(), expected_chars[0].out_char,
                     expected_chars[0].char_class);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   xmlcc_pkg::req_type req_payload;
   logic               rsp_valid;
   logic               rsp_ready;
   xmlcc_pkg::rsp_type rsp_payload;

   xml_class_scoreboard board;
   int items_sent;
   bit send_calm;
   bit take_calm;

   xml_markup_char_classifier u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

   // one item on the input channel; returns at the edge where it is taken
   task automatic send_item(input xmlcc_pkg::req_type item);
      int gap;
      if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_item(item);
      items_sent++;
   endtask

   task automatic send_char(input xmlcc_pkg::char_type c);
      xmlcc_pkg::req_type item;
      item.item_kind = xmlcc_pkg::KIND_CHAR;
      item.char_code = c;
      send_item(item);
   endtask

   // line end; the unused code field still carries random bits
   task automatic send_eol();
      xmlcc_pkg::req_type item;
      item.item_kind = xmlcc_pkg::KIND_EOL;
      item.char_code = xmlcc_pkg::char_type'($urandom);
      send_item(item);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_char(xmlcc_pkg::char_type'(s[i]));
   endtask

   // hold off the input until every predicted result is out
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic xmlcc_pkg::char_type letter();
      return CH_A + xmlcc_pkg::char_type'($urandom_range(0, 25));
   endfunction

   // mostly letters, now and then a markup character
   function automatic xmlcc_pkg::char_type pick_char();
      xmlcc_pkg::char_type specials[8];
      int                  r;
      specials = '{xmlcc_pkg::CH_LT, xmlcc_pkg::CH_GT, xmlcc_pkg::CH_AMP, xmlcc_pkg::CH_SEMI,
                   xmlcc_pkg::CH_DASH, xmlcc_pkg::CH_BANG, xmlcc_pkg::CH_DQUOT,
                   xmlcc_pkg::CH_SQUOT};
      r = $urandom_range(0, 15);
      if (r < 10) return letter();
      if (r == 10) return CH_SPACE;
      return specials[$urandom_range(0, 7)];
   endfunction

   task automatic send_word(input int n);
      repeat (n) send_char(letter());
   endtask

   task automatic send_tag();
      int                  n_attr;
      xmlcc_pkg::char_type q;
      send_char(xmlcc_pkg::CH_LT);
      if ($urandom_range(0, 3) == 0) send_char(CH_SLASH);
      send_word($urandom_range(1, 4));
      n_attr = $urandom_range(0, 2);
      repeat (n_attr) begin
         send_char(CH_SPACE);
         send_word($urandom_range(1, 3));
         send_char(CH_EQ);
         q = $urandom_range(0, 1) ? xmlcc_pkg::CH_SQUOT : xmlcc_pkg::CH_DQUOT;
         send_char(q);
         // values may hold the other quote, markup and line ends
         repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 7) == 0) send_eol();
            else send_char(pick_char());
         end
         send_char(q);
      end
      if ($urandom_range(0, 9) != 0) send_char(xmlcc_pkg::CH_GT);
   endtask

   task automatic send_comment();
      int r;
      send_char(xmlcc_pkg::CH_LT);
      send_char(xmlcc_pkg::CH_BANG);
      send_char(xmlcc_pkg::CH_DASH);
      send_char(xmlcc_pkg::CH_DASH);
      repeat ($urandom_range(0, 6)) begin
         r = $urandom_range(0, 9);
         if (r == 0) send_eol();
         else if (r < 3) send_char(xmlcc_pkg::CH_DASH);
         else if (r == 3) send_char(xmlcc_pkg::CH_GT);
         else send_char(pick_char());
      end
      if ($urandom_range(0, 9) != 0) begin
         send_char(xmlcc_pkg::CH_DASH);
         send_char(xmlcc_pkg::CH_DASH);
         send_char(xmlcc_pkg::CH_GT);
      end
   endtask

   task automatic send_entity();
      send_char(xmlcc_pkg::CH_AMP);
      send_word($urandom_range(0, 4));
      if ($urandom_range(0, 4) != 0) send_char(xmlcc_pkg::CH_SEMI);
   endtask

   // openers cut short by a line end or a wrong character
   task automatic send_broken();
      int depth;
      depth = $urandom_range(0, 2);
      send_char(xmlcc_pkg::CH_LT);
      if (depth > 0) send_char(xmlcc_pkg::CH_BANG);
      if (depth > 1) send_char(xmlcc_pkg::CH_DASH);
      if ($urandom_range(0, 1) == 0) send_eol();
      else send_char(pick_char());
   endtask

   task automatic send_fragment();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         repeat ($urandom_range(1, 6)) send_char(pick_char());
      end else if (pick < 34) begin
         send_entity();
      end else if (pick < 56) begin
         send_tag();
      end else if (pick < 72) begin
         send_comment();
      end else if (pick < 84) begin
         send_eol();
      end else if (pick < 92) begin
         send_broken();
      end else begin
         // full-width noise codes
         repeat ($urandom_range(1, 3)) send_char(xmlcc_pkg::char_type'($urandom));
      end
   endtask

   // result side: random stalls, with calm stretches
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
         gap = take_calm ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_result(rsp_payload);
      end
   end

   initial begin
      bit paused;
      board       = new();
      items_sent  = 0;
      send_calm   = 1'b0;
      take_calm   = 1'b0;
      paused      = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: line end with nothing held
      send_eol();
      // opener whose own dashes close the comment, fourth character held over
      send_text("<!-->");
      send_eol();
      // lone '<' before a line end opens a tag
      send_char(xmlcc_pkg::CH_LT);
      send_eol();
      // '<' inside an entity stays an entity character
      send_text("&<;");
      // opener broken at its third character
      send_text("<!x");
      // quotes inside the tag, then '>' back to text
      send_text("'\"'>");
      // code extremes as plain text
      send_char(xmlcc_pkg::char_type'(16'hFFFF));
      send_char(xmlcc_pkg::char_type'(16'h0000));
      send_eol();
      // entity running to the end of the line
      send_text("&x");
      send_eol();
      drain();

      // random well-formed markup mixed with noise
      while (items_sent < RANDOM_ITEMS) begin
         if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
            drain();
            paused = 1'b1;
         end
         send_fragment();
      end
      send_eol();
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      board.flag_leftovers();
      if (board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
